/* design/spq_pkg.sv */
// Shared constants and codes for the stable priority queue.
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int KIND_BITS_DEF   = 8;

  localparam int ID_W     = 16;
  localparam int KIND_W   = 8;
  localparam int PRIO_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

endpackage

/* design/spq_core.sv */
// Entry memory, circular sorted list and sequencer of the stable priority queue.
module spq_core import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int KIND_BITS   = KIND_BITS_DEF,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  logic                     req_op_i,
  input  logic [ID_W-1:0]          req_id_i,
  input  logic [KIND_W-1:0]        req_kind_i,
  input  logic signed [PRIO_W-1:0] req_prio_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic [STATUS_W-1:0]      res_status_o,
  output logic [CNT_W-1:0]         res_count_o,
  output logic [ID_W-1:0]          res_id_o,
  output logic [KIND_W-1:0]        res_kind_o,
  output logic signed [PRIO_W-1:0] res_prio_o
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int ENT_W = ID_W + KIND_BITS + PRIO_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DUP   = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CNT_W-1:0]          idx_q, idx_d;
  logic [AW-1:0]             head_q, head_d;
  logic                      dup_q, dup_d;
  logic                      rv_q, rv_d;
  logic [ID_W-1:0]           new_id_q, new_id_d;
  logic [KIND_BITS-1:0]      new_kind_q, new_kind_d;
  logic signed [PRIO_W-1:0]  new_prio_q, new_prio_d;
  logic [STATUS_W-1:0]       res_status_q, res_status_d;
  logic [ID_W-1:0]           res_id_q, res_id_d;
  logic [KIND_W-1:0]         res_kind_q, res_kind_d;
  logic signed [PRIO_W-1:0]  res_prio_q, res_prio_d;

  logic [ENT_W-1:0]          store_q [QUEUE_DEPTH];
  logic [ENT_W-1:0]          rd_q;
  logic                      mem_re, mem_we;
  logic [AW-1:0]             mem_ra, mem_wa;
  logic [ENT_W-1:0]          mem_wd;

  logic [ID_W-1:0]           rd_id;
  logic [KIND_BITS-1:0]      rd_kind;
  logic signed [PRIO_W-1:0]  rd_prio;
  logic [ENT_W-1:0]          new_ent;

  assign rd_id   = rd_q[ID_W-1:0];
  assign rd_kind = rd_q[ID_W +: KIND_BITS];
  assign rd_prio = rd_q[ENT_W-1 -: PRIO_W];
  assign new_ent = {new_prio_q, new_kind_q, new_id_q};

  function automatic logic [AW-1:0] phys(input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head_q) + {1'b0, off};
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) s = s - (CNT_W+1)'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    head_d       = head_q;
    dup_d        = dup_q;
    rv_d         = rv_q;
    new_id_d     = new_id_q;
    new_kind_d   = new_kind_q;
    new_prio_d   = new_prio_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_kind_d   = res_kind_q;
    res_prio_d   = res_prio_q;
    mem_re       = 1'b0;
    mem_ra       = '0;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = new_ent;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          new_id_d   = req_id_i;
          new_kind_d = KIND_BITS'(req_kind_i);
          new_prio_d = req_prio_i;
          res_id_d   = '0;
          res_kind_d = '0;
          res_prio_d = '0;
          if (req_op_i == OP_INSERT) begin
            dup_d   = 1'b0;
            rv_d    = 1'b0;
            idx_d   = '0;
            state_d = S_DUP;
          end else if (count_q == '0) begin
            res_status_d = ST_EMPTY;
            state_d      = S_DONE;
          end else begin
            mem_re  = 1'b1;
            mem_ra  = head_q;
            state_d = S_POP;
          end
        end
      end
      S_DUP: begin
        rv_d  = 1'b0;
        dup_d = dup_q | (rv_q && (rd_id == new_id_q));
        if (idx_q != count_q) begin
          mem_re = 1'b1;
          mem_ra = phys(idx_q);
          idx_d  = idx_q + 1'b1;
          rv_d   = 1'b1;
        end else if (!rv_q) begin
          if ((new_id_q == '0) || dup_q) begin
            res_status_d = ST_BAD_ID;
            state_d      = S_DONE;
          end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
            res_status_d = ST_FULL;
            state_d      = S_DONE;
          end else if (count_q == '0) begin
            idx_d   = '0;
            state_d = S_PLACE;
          end else begin
            mem_re  = 1'b1;
            mem_ra  = phys(count_q - 1'b1);
            idx_d   = count_q;
            state_d = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        mem_we = 1'b1;
        mem_wa = phys(idx_q);
        if (rd_prio > new_prio_q) begin
          mem_wd = rd_q;
          idx_d  = idx_q - 1'b1;
          if (idx_q != CNT_W'(1)) begin
            mem_re = 1'b1;
            mem_ra = phys(idx_q - CNT_W'(2));
          end else begin
            state_d = S_PLACE;
          end
        end else begin
          count_d      = count_q + 1'b1;
          res_status_d = ST_OK;
          state_d      = S_DONE;
        end
      end
      S_PLACE: begin
        mem_we       = 1'b1;
        mem_wa       = phys(idx_q);
        count_d      = count_q + 1'b1;
        res_status_d = ST_OK;
        state_d      = S_DONE;
      end
      S_POP: begin
        res_status_d = ST_OK;
        res_id_d     = rd_id;
        res_kind_d   = KIND_W'(rd_kind);
        res_prio_d   = rd_prio;
        count_d      = count_q - 1'b1;
        head_d       = phys(CNT_W'(1));
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      head_q  <= '0;
      dup_q   <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      head_q  <= head_d;
      dup_q   <= dup_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_id_q     <= new_id_d;
    new_kind_q   <= new_kind_d;
    new_prio_q   <= new_prio_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_kind_q   <= res_kind_d;
    res_prio_q   <= res_prio_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) store_q[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= store_q[mem_ra];
  end

  assign req_ready_o  = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);
  assign res_status_o = res_status_q;
  assign res_count_o  = count_q;
  assign res_id_o     = res_id_q;
  assign res_kind_o   = res_kind_q;
  assign res_prio_o   = res_prio_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

  a_write_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_SHIFT || state_q == S_PLACE))
    else $error("memory write outside insert");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |=> (count_q == $past(count_q) - 1'b1))
    else $error("remove did not drop the count");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(head_q) < QUEUE_DEPTH)
    else $error("head pointer out of range");

  a_place_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLACE) |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not raise the count");

endmodule

/* design/stable_priority_queue_top.sv */
// Insert reads one memory entry a cycle for the duplicate scan, then moves one a cycle
// for the ordered shift; remove reads only the head entry.
// Throughput: one word at a time, set by the single read and write port of the entry
// memory; the next word is taken while a result waits in the output register.
// Reset: asynchronous, active low; clears count, head pointer and sequencer. The entry
// memory holds no reset value and is only read below the count.
module stable_priority_queue_top import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int KIND_BITS   = KIND_BITS_DEF,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_RAW_W  = CNT_W + ID_W + KIND_W + PRIO_W,
  localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [55:0]         s_axis_tdata_i,   // item_id, item_kind, priority_req
  input  logic                s_axis_tuser_i,   // opcode
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OUT_W-1:0]    m_axis_tdata_o,   // count, out_item_id, out_kind, out_priority
  output logic [STATUS_W-1:0] m_axis_tuser_o    // status
);

  logic                     res_valid, res_ready;
  logic [STATUS_W-1:0]      res_status;
  logic [CNT_W-1:0]         res_count;
  logic [ID_W-1:0]          res_id;
  logic [KIND_W-1:0]        res_kind;
  logic signed [PRIO_W-1:0] res_prio;

  logic                     m_valid_q;
  logic [OUT_W-1:0]         m_data_q;
  logic [STATUS_W-1:0]      m_user_q;

  spq_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .KIND_BITS  (KIND_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_op_i    (s_axis_tuser_i),
    .req_id_i    (s_axis_tdata_i[15:0]),
    .req_kind_i  (s_axis_tdata_i[23:16]),
    .req_prio_i  (s_axis_tdata_i[55:24]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_status_o(res_status),
    .res_count_o (res_count),
    .res_id_o    (res_id),
    .res_kind_o  (res_kind),
    .res_prio_o  (res_prio)
  );

  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_data_q <= OUT_W'({res_prio, res_kind, res_id, res_count});
      m_user_q <= res_status;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

/* tb/stable_priority_queue_top_tb.sv */
// Self-checking testbench for the stable priority queue top level.
`timescale 1ns / 1ps

module stable_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int QDEPTH       = QUEUE_DEPTH_DEF;
  localparam int CNT_W        = $clog2(QDEPTH + 1);
  localparam int OUT_RAW_W    = CNT_W + ID_W + KIND_W + PRIO_W;
  localparam int OUT_W        = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int WORD_TARGET  = 1250;
  localparam logic [KIND_W-1:0] KIND_MASK = KIND_W'((1 << KIND_BITS_DEF) - 1);

  typedef struct {
    logic [ID_W-1:0]          id;
    logic [KIND_W-1:0]        kind;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
    entry_t              removed;
  } reply_t;

  class queue_tracker;
    entry_t      held[$];
    reply_t      pending[$];
    int unsigned fails;

    function void take_word(logic op, entry_t e);
      reply_t r;
      int     pos;
      bit     dup;
      r.status       = ST_OK;
      r.removed.id   = '0;
      r.removed.kind = '0;
      r.removed.prio = '0;
      if (op == OP_INSERT) begin
        e.kind = e.kind & KIND_MASK;
        dup    = 1'b0;
        foreach (held[i]) if (held[i].id == e.id) dup = 1'b1;
        if (e.id == '0 || dup) begin
          r.status = ST_BAD_ID;
        end else if (held.size() >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held.size() && held[pos].prio <= e.prio) pos++;
          held.insert(pos, e);
        end
      end else if (held.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed = held.pop_front();
      end
      r.count = CNT_W'(held.size());
      pending.push_back(r);
    endfunction

    function void check_word(logic [OUT_W-1:0] data, logic [STATUS_W-1:0] st);
      reply_t                   r;
      logic [CNT_W-1:0]         cnt;
      logic [ID_W-1:0]          id;
      logic [KIND_W-1:0]        kind;
      logic signed [PRIO_W-1:0] prio;
      if (pending.size() == 0) begin
        fails++;
        $error("result word with nothing pending: status %0d, data %h", st, data);
        return;
      end
      r    = pending.pop_front();
      cnt  = data[CNT_W-1:0];
      id   = data[CNT_W +: ID_W];
      kind = data[CNT_W + ID_W +: KIND_W];
      prio = data[CNT_W + ID_W + KIND_W +: PRIO_W];
      if (st !== r.status) begin
        fails++;
        $error("status: expected %0d, got %0d", r.status, st);
      end
      if (cnt !== r.count) begin
        fails++;
        $error("count: expected %0d, got %0d", r.count, cnt);
      end
      if (id !== r.removed.id) begin
        fails++;
        $error("out_item_id: expected %0d, got %0d", r.removed.id, id);
      end
      if (kind !== r.removed.kind) begin
        fails++;
        $error("out_kind: expected %0d, got %0d", r.removed.kind, kind);
      end
      if (prio !== r.removed.prio) begin
        fails++;
        $error("out_priority: expected %0d, got %0d", r.removed.prio, prio);
      end
    endfunction
  endclass

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [55:0]         s_axis_tdata_i  = '0;  // item_id, item_kind, priority_req
  logic                s_axis_tuser_i  = 1'b0; // opcode
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata_o;         // count, out_item_id, out_kind, out_priority
  logic [STATUS_W-1:0] m_axis_tuser_o;         // status

  queue_tracker tracker = new;
  int unsigned  words_sent  = 0;
  int unsigned  cycle_count = 0;
  bit           quiet       = 1'b0;

  stable_priority_queue_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o === 1'b1 && m_axis_tready_i)
      tracker.check_word(m_axis_tdata_o, m_axis_tuser_o);
  end

  // stall the result side at random before each word, but not while quiet
  initial begin
    int stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid_o !== 1'b1);
    end
  end

  task automatic send_word(logic op, logic [ID_W-1:0] id, logic [KIND_W-1:0] kind,
                           logic signed [PRIO_W-1:0] prio);
    int     gap;
    entry_t e;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {prio, kind, id};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    e.id   = id;
    e.kind = kind;
    e.prio = prio;
    tracker.take_word(op, e);
    words_sent++;
  endtask

  task automatic send_remove();
    send_word(OP_REMOVE, ID_W'($urandom), KIND_W'($urandom), PRIO_W'($urandom));
  endtask

  task automatic await_results();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 23 && tracker.held.size() > 0)
      return tracker.held[$urandom_range(0, tracker.held.size() - 1)].id;
    if (r < 33) return ID_W'($urandom);
    return ID_W'($urandom_range(1, 300));
  endfunction

  function automatic logic signed [PRIO_W-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $signed($urandom_range(0, 6)) - 3;
    if (r < 50) begin
      case ($urandom_range(0, 5))
        0: return 32'sh80000000;
        1: return 32'sh80000001;
        2: return 32'sh7FFFFFFF;
        3: return 32'sh7FFFFFFE;
        4: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic run_phase(int len, int insert_pct);
    repeat (len) begin
      if ($urandom_range(0, 99) < insert_pct)
        send_word(OP_INSERT, pick_id(), KIND_W'($urandom), pick_prio());
      else
        send_remove();
    end
  endtask

  initial begin
    int pct[4];
    pct = '{90, 50, 25, 60};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_remove();
    send_word(OP_INSERT, '0,       8'h5A, 32'sd7);
    send_word(OP_INSERT, 16'hFFFF, 8'hFF, 32'sh7FFFFFFF);
    send_word(OP_INSERT, 16'h0001, 8'h00, 32'sh80000000);
    send_word(OP_INSERT, 16'hAAAA, 8'hAA, 32'sd5);
    send_word(OP_INSERT, 16'h5555, 8'h55, 32'sd5);
    send_word(OP_INSERT, 16'h0002, 8'h0F, 32'sd5);
    send_word(OP_INSERT, 16'hFFFF, 8'h01, -32'sd1);
    send_word(OP_INSERT, 16'h00F0, 8'hF0, 32'sd0);
    send_word(OP_INSERT, 16'h0F00, 8'h33, -32'sd1);
    repeat (9) send_remove();
    await_results();

    // fill up, then hit the full and duplicate-on-full cases
    while (tracker.held.size() < QDEPTH)
      send_word(OP_INSERT, pick_id(), KIND_W'($urandom), pick_prio());
    run_phase(10, 100);
    await_results();
    while (tracker.held.size() > 0) send_remove();
    repeat (2) send_remove();

    while (words_sent < WORD_TARGET) begin
      quiet = ($urandom_range(0, 4) == 0);
      run_phase($urandom_range(40, 120), pct[$urandom_range(0, 3)]);
      if ($urandom_range(0, 2) == 0) await_results();
    end

    await_results();
    repeat (20) @(posedge clk_i);
    if (tracker.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
